FILE: rtl/brle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brle_pkg
// shared types and constants of the bmp rle8/rle4 palette decoder
// ----------------------------------------------------------------------------
package brle_pkg;

  // configuration register field and image geometry
  localparam int unsigned CfgBits   = 13;
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColMax    = 8191;
  // linear pixel pointer, holds up to width * height
  localparam int unsigned PixBits   = 2 * CfgBits;

  // payload widths
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned ColorBits = 24;
  localparam int unsigned AddrBits  = 24;
  localparam int unsigned KindBits  = 2;
  localparam int unsigned CfgIdxBits = 2;

  localparam int unsigned DefaultPaletteEntries = 256;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_RLE_MODE     = 2'd2
  } cfg_index_e;

  // input commands
  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_STREAM  = 1'b1
  } command_e;

  // output record kinds
  typedef enum logic [KindBits-1:0] {
    KIND_RUN    = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2
  } record_kind_e;

  // stream escape codes
  localparam logic [ByteBits-1:0] EscEndOfLine   = 8'h00;
  localparam logic [ByteBits-1:0] EscEndOfBitmap = 8'h01;
  localparam logic [ByteBits-1:0] EscDelta       = 8'h02;

endpackage : brle_pkg
`default_nettype wire

FILE: rtl/brle_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brle_in_if
// input channel: palette writes and compressed stream bytes
// ----------------------------------------------------------------------------
interface brle_in_if;
  import brle_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ByteBits-1:0]  palette_index;
  logic [ColorBits-1:0] palette_color;
  logic [ByteBits-1:0]  stream_byte;

  modport source (
    output valid, command, palette_index, palette_color, stream_byte,
    input  ready
  );

  modport sink (
    input  valid, command, palette_index, palette_color, stream_byte,
    output ready
  );

endinterface : brle_in_if
`default_nettype wire

FILE: rtl/brle_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brle_out_if
// output channel: pixel run, finished and error records
// ----------------------------------------------------------------------------
interface brle_out_if;
  import brle_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KindBits-1:0]  record_kind;
  logic [AddrBits-1:0]  start_address;
  logic [ByteBits-1:0]  run_length;
  logic [ColorBits-1:0] even_color;
  logic [ColorBits-1:0] odd_color;

  modport source (
    output valid, record_kind, start_address, run_length, even_color, odd_color,
    input  ready
  );

  modport sink (
    input  valid, record_kind, start_address, run_length, even_color, odd_color,
    output ready
  );

endinterface : brle_out_if
`default_nettype wire

FILE: rtl/brle_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brle_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module brle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : brle_ram
`default_nettype wire

FILE: rtl/bmp_rle_palette_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_rle_palette_decoder
// bmp rle8 / rle4 stream decoder with a loadable colour palette
// ----------------------------------------------------------------------------
//
// channel   dir  handshake      transaction
// --------  ---  -------------  ------------------------------------------------
// in_ch     in   valid/ready    palette write or one compressed stream byte
// out_ch    out  valid/ready    pixel run, bitmap finished or error record
// cfg_*     in   write enable   image width, image height, rle mode
//
// one input transaction per cycle unless settling or back-pressured; a run or
// literal byte gives its record via the palette read, then the output register
// the palette lives in two copies of one ram so that both nibble colours of a
// rle4 byte are read in the same cycle; all parse state sits in flip-flops
// reset, and every width, height or mode write, restarts decoding; in the cycle
// after such a write (and after reset) the input is held off once while the
// image size products are computed
// the input stays open while one record waits at a stalled output
// ----------------------------------------------------------------------------
module bmp_rle_palette_decoder #(
  parameter int unsigned PaletteEntries = brle_pkg::DefaultPaletteEntries
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [brle_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [brle_pkg::CfgBits-1:0]    cfg_data_i,
  brle_in_if.sink                              in_ch,
  brle_out_if.source                           out_ch
);

  import brle_pkg::*;

  localparam int unsigned PalAddrBits = $clog2(PaletteEntries);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_RUNVAL,
    PH_ESCAPE,
    PH_DX,
    PH_DY,
    PH_LITERAL,
    PH_PAD
  } phase_e;

  // configuration
  logic [CfgBits-1:0] width_q, width_d;
  logic [CfgBits-1:0] height_q, height_d;
  logic               rle4_q, rle4_d;
  logic               settle_q, settle_d;

  // image geometry products
  logic [PixBits-1:0] total_q, total_d;
  logic [PixBits-1:0] row_base_q, row_base_d;

  // parse state
  phase_e              phase_q, phase_d;
  logic [PixBits-1:0]  wp_q, wp_d;
  logic [CfgBits-1:0]  row_q, row_d;
  logic [CfgBits-1:0]  col_q, col_d;
  logic [ByteBits-1:0] held_q, held_d;
  logic [ByteBits-1:0] lit_left_q, lit_left_d;
  logic                pad_q, pad_d;
  logic [ByteBits-1:0] dx_q, dx_d;
  logic                fin_q, fin_d;

  // palette valid bits, one per entry
  logic [PaletteEntries-1:0] pal_valid_q, pal_valid_d;

  // palette read stage
  logic                s1_valid_q, s1_valid_d;
  record_kind_e        s1_kind_q, s1_kind_d;
  logic [PixBits-1:0]  s1_addr_q, s1_addr_d;
  logic [ByteBits-1:0] s1_len_q, s1_len_d;
  logic                s1_ok_a_q, s1_ok_a_d;
  logic                s1_ok_b_q, s1_ok_b_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  record_kind_e         out_kind_q, out_kind_d;
  logic [AddrBits-1:0]  out_addr_q, out_addr_d;
  logic [ByteBits-1:0]  out_len_q, out_len_d;
  logic [ColorBits-1:0] out_even_q, out_even_d;
  logic [ColorBits-1:0] out_odd_q, out_odd_d;

  // combinational helpers
  logic [CfgBits-1:0]   eff_w, eff_h;
  logic [PixBits-1:0]   total_c, row0_c, dyw_c, rem_c;
  logic                 s1_adv, in_ready, in_acc, stream_acc, pal_acc;
  logic [ByteBits-1:0]  b;
  logic [ByteBits-1:0]  rd_idx_a, rd_idx_b;
  logic                 rd_in_a, rd_in_b, wr_in;
  logic [ColorBits-1:0] rdata_a, rdata_b;
  logic [ByteBits-1:0]  pp_len, lit_len, lit_left_nx, held_nx;
  logic                 pp_err, do_put;
  logic [CfgBits:0]     col_sum, dx_sum, dy_sum;
  logic [ByteBits:0]    lit_bytes;

  // effective image size, clamped
  always_comb begin
    eff_w = width_q;
    if (width_q == '0) begin
      eff_w = CfgBits'(1);
    end else if (width_q > CfgBits'(MaxWidth)) begin
      eff_w = CfgBits'(MaxWidth);
    end
    eff_h = height_q;
    if (height_q == '0) begin
      eff_h = CfgBits'(1);
    end else if (height_q > CfgBits'(MaxHeight)) begin
      eff_h = CfgBits'(MaxHeight);
    end
  end

  assign total_c = PixBits'(eff_w) * PixBits'(eff_h);
  assign row0_c  = total_c - PixBits'(eff_w);

  // handshake
  assign s1_adv     = !out_valid_q || out_ch.ready;
  assign in_ready   = !settle_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_ch.valid && in_ready;
  assign stream_acc = in_acc && (in_ch.command == CMD_STREAM);
  assign pal_acc    = in_acc && (in_ch.command == CMD_PALETTE);
  assign b          = in_ch.stream_byte;

  // palette read addresses: both nibbles in rle4, the whole byte in rle8
  assign rd_idx_a = rle4_q ? {4'b0, b[7:4]} : b;
  assign rd_idx_b = rle4_q ? {4'b0, b[3:0]} : b;
  assign rd_in_a  = ((ByteBits + 1)'(rd_idx_a) < (ByteBits + 1)'(PaletteEntries));
  assign rd_in_b  = ((ByteBits + 1)'(rd_idx_b) < (ByteBits + 1)'(PaletteEntries));
  assign wr_in    =
    ((ByteBits + 1)'(in_ch.palette_index) < (ByteBits + 1)'(PaletteEntries));

  brle_ram #(
    .Width (ColorBits),
    .Depth (PaletteEntries)
  ) u_pal_even (
    .clk_i   (clk_i),
    .we_i    (pal_acc && wr_in),
    .waddr_i (in_ch.palette_index[PalAddrBits-1:0]),
    .wdata_i (in_ch.palette_color),
    .re_i    (stream_acc),
    .raddr_i (rd_idx_a[PalAddrBits-1:0]),
    .rdata_o (rdata_a)
  );

  brle_ram #(
    .Width (ColorBits),
    .Depth (PaletteEntries)
  ) u_pal_odd (
    .clk_i   (clk_i),
    .we_i    (pal_acc && wr_in),
    .waddr_i (in_ch.palette_index[PalAddrBits-1:0]),
    .wdata_i (in_ch.palette_color),
    .re_i    (stream_acc),
    .raddr_i (rd_idx_b[PalAddrBits-1:0]),
    .rdata_o (rdata_b)
  );

  // literal byte bookkeeping
  always_comb begin
    lit_len = ByteBits'(1);
    if (rle4_q) begin
      lit_len = (held_q >= ByteBits'(2)) ? ByteBits'(2) : held_q;
    end
    lit_left_nx = (lit_left_q != '0) ? lit_left_q - ByteBits'(1) : '0;
    held_nx     = held_q - lit_len;
    lit_bytes   = rle4_q ? ((ByteBits + 1)'(b) + (ByteBits + 1)'(1)) >> 1
                         : (ByteBits + 1)'(b);
  end

  // pixel placement bounds and delta arithmetic
  assign pp_len  = (phase_q == PH_LITERAL) ? lit_len : held_q;
  assign rem_c   = total_q - wp_q;
  assign pp_err  = PixBits'(pp_len) > rem_c;
  assign col_sum = (CfgBits + 1)'(col_q) + (CfgBits + 1)'(pp_len);
  assign dx_sum  = (CfgBits + 1)'(col_q) + (CfgBits + 1)'(dx_q);
  assign dy_sum  = (CfgBits + 1)'(row_q) + (CfgBits + 1)'(b);
  assign dyw_c   = PixBits'(b) * PixBits'(eff_w);

  // parser
  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    rle4_d      = rle4_q;
    settle_d    = settle_q;
    total_d     = total_q;
    row_base_d  = row_base_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    row_d       = row_q;
    col_d       = col_q;
    held_d      = held_q;
    lit_left_d  = lit_left_q;
    pad_d       = pad_q;
    dx_d        = dx_q;
    fin_d       = fin_q;
    pal_valid_d = pal_valid_q;
    do_put      = 1'b0;
    s1_valid_d  = s1_valid_q && !s1_adv;
    s1_kind_d   = s1_kind_q;
    s1_addr_d   = s1_addr_q;
    s1_len_d    = s1_len_q;
    s1_ok_a_d   = s1_ok_a_q;
    s1_ok_b_d   = s1_ok_b_q;

    if (pal_acc && wr_in) begin
      pal_valid_d[in_ch.palette_index[PalAddrBits-1:0]] = 1'b1;
    end

    if (cfg_we_i && (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT
                     || cfg_index_i == CFG_RLE_MODE)) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        CFG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default:          rle4_d   = cfg_data_i[0];
      endcase
      // restart decoding, geometry is reloaded in the settle cycle
      settle_d   = 1'b1;
      phase_d    = PH_COUNT;
      row_d      = '0;
      col_d      = '0;
      held_d     = '0;
      lit_left_d = '0;
      pad_d      = 1'b0;
      dx_d       = '0;
      fin_d      = 1'b0;
    end else if (settle_q) begin
      settle_d   = 1'b0;
      total_d    = total_c;
      row_base_d = row0_c;
      wp_d       = row0_c;
    end else if (stream_acc && !fin_q) begin
      unique case (phase_q)
        PH_RUNVAL: begin
          phase_d = PH_COUNT;
          do_put  = 1'b1;
        end
        PH_ESCAPE: begin
          phase_d = PH_COUNT;
          priority if (b == EscEndOfLine) begin
            row_d = row_q + CfgBits'(1);
            if (dy_sum - (CfgBits + 1)'(b) + (CfgBits + 1)'(1) >= (CfgBits + 1)'(eff_h)) begin
              fin_d      = 1'b1;
              s1_valid_d = 1'b1;
              s1_kind_d  = KIND_DONE;
            end else begin
              col_d      = '0;
              row_base_d = row_base_q - PixBits'(eff_w);
              wp_d       = row_base_q - PixBits'(eff_w);
            end
          end else if (b == EscEndOfBitmap) begin
            fin_d      = 1'b1;
            s1_valid_d = 1'b1;
            s1_kind_d  = KIND_DONE;
          end else if (b == EscDelta) begin
            phase_d = PH_DX;
          end else begin
            held_d     = b;
            lit_left_d = lit_bytes[ByteBits-1:0];
            pad_d      = lit_bytes[0];
            phase_d    = PH_LITERAL;
          end
        end
        PH_DX: begin
          dx_d    = b;
          phase_d = PH_DY;
        end
        PH_DY: begin
          phase_d = PH_COUNT;
          if (dx_sum >= (CfgBits + 1)'(eff_w) || dy_sum >= (CfgBits + 1)'(eff_h)) begin
            fin_d      = 1'b1;
            s1_valid_d = 1'b1;
            s1_kind_d  = KIND_ERROR;
          end else begin
            row_d      = dy_sum[CfgBits-1:0];
            col_d      = dx_sum[CfgBits-1:0];
            row_base_d = row_base_q - dyw_c;
            wp_d       = row_base_q - dyw_c + PixBits'(dx_sum);
          end
        end
        PH_LITERAL: begin
          held_d     = held_nx;
          lit_left_d = lit_left_nx;
          if (held_nx == '0 || lit_left_nx == '0) begin
            held_d     = '0;
            lit_left_d = '0;
            phase_d    = pad_q ? PH_PAD : PH_COUNT;
          end
          do_put = 1'b1;
        end
        PH_PAD: begin
          pad_d   = 1'b0;
          phase_d = PH_COUNT;
        end
        default: begin
          // count byte: nonzero starts an encoded run, zero an escape
          if (b != '0) begin
            held_d  = b;
            phase_d = PH_RUNVAL;
          end else begin
            phase_d = PH_ESCAPE;
          end
        end
      endcase

      if (do_put) begin
        s1_valid_d = 1'b1;
        if (pp_err) begin
          fin_d     = 1'b1;
          phase_d   = PH_COUNT;
          s1_kind_d = KIND_ERROR;
        end else begin
          wp_d      = wp_q + PixBits'(pp_len);
          col_d     = (col_sum > (CfgBits + 1)'(ColMax)) ? CfgBits'(ColMax)
                                                         : col_sum[CfgBits-1:0];
          s1_kind_d = KIND_RUN;
          s1_addr_d = wp_q;
          s1_len_d  = pp_len;
          s1_ok_a_d = rd_in_a && pal_valid_q[rd_idx_a[PalAddrBits-1:0]];
          s1_ok_b_d = rd_in_b && pal_valid_q[rd_idx_b[PalAddrBits-1:0]];
        end
      end
    end
  end

  // output register: colours come straight from the palette read
  always_comb begin
    out_valid_d = out_valid_q && !out_ch.ready;
    out_kind_d  = out_kind_q;
    out_addr_d  = out_addr_q;
    out_len_d   = out_len_q;
    out_even_d  = out_even_q;
    out_odd_d   = out_odd_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
      out_kind_d  = s1_kind_q;
      if (s1_kind_q == KIND_RUN) begin
        out_addr_d = s1_addr_q[AddrBits-1:0];
        out_len_d  = s1_len_q;
        out_even_d = s1_ok_a_q ? rdata_a : '0;
        out_odd_d  = s1_ok_b_q ? rdata_b : '0;
      end else begin
        out_addr_d = '0;
        out_len_d  = '0;
        out_even_d = '0;
        out_odd_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CfgBits'(1);
      height_q    <= CfgBits'(1);
      rle4_q      <= 1'b0;
      settle_q    <= 1'b1;
      total_q     <= PixBits'(1);
      row_base_q  <= '0;
      phase_q     <= PH_COUNT;
      wp_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      held_q      <= '0;
      lit_left_q  <= '0;
      pad_q       <= 1'b0;
      dx_q        <= '0;
      fin_q       <= 1'b0;
      pal_valid_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      rle4_q      <= rle4_d;
      settle_q    <= settle_d;
      total_q     <= total_d;
      row_base_q  <= row_base_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      row_q       <= row_d;
      col_q       <= col_d;
      held_q      <= held_d;
      lit_left_q  <= lit_left_d;
      pad_q       <= pad_d;
      dx_q        <= dx_d;
      fin_q       <= fin_d;
      pal_valid_q <= pal_valid_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_kind_q  <= s1_kind_d;
    s1_addr_q  <= s1_addr_d;
    s1_len_q   <= s1_len_d;
    s1_ok_a_q  <= s1_ok_a_d;
    s1_ok_b_q  <= s1_ok_b_d;
    out_kind_q <= out_kind_d;
    out_addr_q <= out_addr_d;
    out_len_q  <= out_len_d;
    out_even_q <= out_even_d;
    out_odd_q  <= out_odd_d;
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_q;
  assign out_ch.record_kind   = out_kind_q;
  assign out_ch.start_address = out_addr_q;
  assign out_ch.run_length    = out_len_q;
  assign out_ch.even_color    = out_even_q;
  assign out_ch.odd_color     = out_odd_q;

endmodule : bmp_rle_palette_decoder
`default_nettype wire
